FILE: rtl/core/sit2d_pkg.sv
// Shared types and constants for the 2D segment intersection test.
package sit2d_pkg;

  typedef enum logic [2:0] {
    KindBoth      = 3'd0,
    KindFirstPt   = 3'd1,
    KindSecondPt  = 3'd2,
    KindCollinear = 3'd3,
    KindParallel  = 3'd4,
    KindGeneral   = 3'd5
  } kind_e;

  localparam int unsigned TolBits = 32;

  // absolute value of a signed value at most tol
  function automatic logic is_small(input logic signed [79:0] v, input logic [TolBits-1:0] tol);
    logic [79:0] m;
    m = v[79] ? 80'(-v) : 80'(v);
    return m <= {48'd0, tol};
  endfunction

endpackage

FILE: rtl/core/segment_intersection_test_2d.sv
// Result path: front stage 1, front stage 2, then the two-entry back queue, each one registered.
// Throughput: one request/cycle unless output stalls; products, compares pipelined in front.
// Back queue of two entries decouples output stalls.
// Reset: asynchronous active low, clears valid state; tol_q resets to 0.
module segment_intersection_test_2d #(
  parameter int COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [COORD_BITS-1:0] first_start_x_i, first_start_y_i,
  input  logic signed [COORD_BITS-1:0] first_end_x_i, first_end_y_i,
  input  logic signed [COORD_BITS-1:0] second_start_x_i, second_start_y_i,
  input  logic signed [COORD_BITS-1:0] second_end_x_i, second_end_y_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic hit_o,
  output logic [2:0] case_kind_o
);
  import sit2d_pkg::*;
  logic [31:0] tol_q;
  logic qv, qr, qh;
  logic [2:0] qk;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= '0;
    else if (cfg_we_i) tol_q <= cfg_wdata_i;
  end
  sit2d_front #(.CW(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .tol_i(tol_q), .in_valid_i, .in_ready_o,
    .ax_i(first_start_x_i), .ay_i(first_start_y_i),
    .bx_i(first_end_x_i), .by_i(first_end_y_i),
    .cx_i(second_start_x_i), .cy_i(second_start_y_i),
    .ex_i(second_end_x_i), .ey_i(second_end_y_i),
    .q_valid_o(qv), .q_ready_i(qr), .q_kind_o(qk), .q_hit_o(qh)
  );
  sit2d_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_kind_i(qk), .q_hit_i(qh),
    .out_valid_o, .out_ready_i, .kind_o(case_kind_o), .hit_o
  );
endmodule

FILE: rtl/core/sit2d_front.sv
// Front: differences, products and case classification, registered.
module sit2d_front #(
  parameter int CW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         tol_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [CW-1:0] ax_i, ay_i, bx_i, by_i, cx_i, cy_i, ex_i, ey_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output logic [2:0]          q_kind_o,
  output logic                q_hit_o
);
  import sit2d_pkg::*;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW + 2;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y, wx, wy;
  logic signed [DW-1:0] p1x, p1y, p2x, p2y;

  // stage 1: differences and products
  logic              s1_v_q;
  logic [2:0]        s1_kind_q;
  logic              s1_pthit_q;
  logic signed [PW-1:0] s1_c1_q, s1_d1_q, s1_l1_q;        // point-on-seg terms
  logic signed [PW-1:0] den_q, nu_q, nt_q, wd1_q, d2d1_q, dd_q;
  logic [2:0]        kind_d;
  logic              s1_en;

  assign d1x = DW'(bx_i) - DW'(ax_i);
  assign d1y = DW'(by_i) - DW'(ay_i);
  assign d2x = DW'(ex_i) - DW'(cx_i);
  assign d2y = DW'(ey_i) - DW'(cy_i);
  assign wx  = DW'(cx_i) - DW'(ax_i);
  assign wy  = DW'(cy_i) - DW'(ay_i);

  logic pt1, pt2;
  assign pt1 = is_small(80'(d1x), tol_i) && is_small(80'(d1y), tol_i);
  assign pt2 = is_small(80'(d2x), tol_i) && is_small(80'(d2y), tol_i);

  // point-on-segment operands: ap from start of other segment, dir of other
  always_comb begin
    if (pt1) begin
      p1x = -wx; p1y = -wy; p2x = d2x; p2y = d2y;
    end else begin
      p1x = wx;  p1y = wy;  p2x = d1x; p2y = d1y;
    end
    if (pt1 && pt2) kind_d = KindBoth;
    else if (pt1)   kind_d = KindFirstPt;
    else if (pt2)   kind_d = KindSecondPt;
    else            kind_d = KindGeneral;
  end

  logic s2_v_q;
  logic s1_ready;
  assign in_ready_o = !s1_v_q || s1_ready;
  assign s1_en = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (in_ready_o) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_kind_q  <= kind_d;
      s1_pthit_q <= is_small(80'(wx), tol_i) && is_small(80'(wy), tol_i);
      s1_c1_q <= PW'(p2x * p1y) - PW'(p2y * p1x);
      s1_d1_q <= PW'(p1x * p2x) + PW'(p1y * p2y);
      s1_l1_q <= PW'(p2x * p2x) + PW'(p2y * p2y);
      den_q   <= PW'(d1x * d2y) - PW'(d1y * d2x);
      nu_q    <= PW'(wx * d1y) - PW'(wy * d1x);
      nt_q    <= PW'(wx * d2y) - PW'(wy * d2x);
      wd1_q   <= PW'(wx * d1x) + PW'(wy * d1y);
      d2d1_q  <= PW'(d2x * d1x) + PW'(d2y * d1y);
      dd_q    <= PW'(d1x * d1x) + PW'(d1y * d1y);
    end
  end

  // stage 2: decisions
  logic [2:0] k2;
  logic       h2;
  logic signed [PW:0] a_w, b_w, hi_w, lo_w, den_a, nt_a, nu_a;
  always_comb begin
    a_w = (PW+1)'(wd1_q);
    b_w = a_w + (PW+1)'(d2d1_q);
    hi_w = (a_w >= b_w) ? a_w : b_w;
    lo_w = (a_w >= b_w) ? b_w : a_w;
    den_a = den_q[PW-1] ? -(PW+1)'(den_q) : (PW+1)'(den_q);
    nt_a  = den_q[PW-1] ? -(PW+1)'(nt_q)  : (PW+1)'(nt_q);
    nu_a  = den_q[PW-1] ? -(PW+1)'(nu_q)  : (PW+1)'(nu_q);
    k2 = s1_kind_q;
    h2 = 1'b0;
    unique case (s1_kind_q)
      KindBoth: h2 = s1_pthit_q;
      KindFirstPt, KindSecondPt:
        h2 = is_small(80'(s1_c1_q), tol_i) && !s1_d1_q[PW-1] && (s1_d1_q <= s1_l1_q);
      default: begin
        if (is_small(80'(den_q), tol_i)) begin
          if (is_small(80'(nu_q), tol_i)) begin
            k2 = KindCollinear;
            h2 = !((hi_w <= 0) || (lo_w >= (PW+1)'(dd_q)));
          end else begin
            k2 = KindParallel;
          end
        end else begin
          h2 = !nt_a[PW] && (nt_a <= den_a) && !nu_a[PW] && (nu_a <= den_a);
        end
      end
    endcase
  end

  assign s1_ready = !s2_v_q || q_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (s1_ready) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (s1_ready && s1_v_q) begin
      q_kind_o <= k2;
      q_hit_o  <= h2;
    end
  end
  assign q_valid_o = s2_v_q;
endmodule

FILE: rtl/core/sit2d_back.sv
// Back: two-entry result queue feeding the output channel.
module sit2d_back (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  logic [2:0] q_kind_i,
  input  logic       q_hit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic       hit_o
);
  logic [3:0] mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  assign q_ready_o   = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = q_valid_i && q_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign {hit_o, kind_o} = mem_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {q_hit_i, q_kind_i};
  end
endmodule
